[hw/rtl/mwdm_pkg.sv]
`default_nettype none

package mwdm_pkg;

  localparam int NUM_WHEELS = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AXLE_SUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP   = 2'd2;

  localparam logic [11:0] AXLE_SUM_RST  = 12'd1331;
  localparam logic [15:0] DUTY_GAIN_RST = 16'd19982;
  localparam logic [15:0] PWM_TOP_RST   = 16'd999;

  // mix is Q.24, duty keeps product bits from here up
  localparam int DUTY_SHIFT = 28;

  typedef enum logic [1:0] {
    DIR_FORWARD = 2'd0,
    DIR_REVERSE = 2'd1,
    DIR_BRAKE   = 2'd2
  } dir_t;

  typedef struct packed {
    logic signed [15:0] fwd_speed;
    logic signed [15:0] side_speed;
    logic signed [15:0] turn_rate;
    logic               stop;
  } mwdm_in_t;

  typedef struct packed {
    logic [15:0] front_left_duty;
    logic [15:0] rear_left_duty;
    logic [15:0] rear_right_duty;
    logic [15:0] front_right_duty;
    dir_t        front_left_dir;
    dir_t        rear_left_dir;
    dir_t        rear_right_dir;
    dir_t        front_right_dir;
  } mwdm_out_t;

endpackage

`default_nettype wire

[hw/rtl/mecanum_wheel_drive_mixer_top.sv]
`default_nettype none

// Mecanum drive mixer: a velocity request (forward, sideways, turn rate in signed
// Q.12, plus stop) turns into a PWM duty and a bridge direction for each of the
// four wheels. A request is taken on every clock where start is high and busy is
// low; busy is only high during reset, so one request per cycle is sustained.
// Each result appears on out_res, with out_valid high for one cycle, after its
// request has passed the five register stages: the turn-rate product and pair
// sums, the four wheel mixes, sign and magnitude, the 29x16 duty multiply, and the
// clamp into the output register. Results cannot be held off, so the receiver must
// take out_res whenever out_valid is high. Configuration writes should only be made
// with no request in flight.
module mecanum_wheel_drive_mixer_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire mwdm_pkg::mwdm_in_t                 in_req,
  output logic                                    out_valid,
  output mwdm_pkg::mwdm_out_t                     out_res,
  input  wire logic                               cfg_we,
  input  wire logic [mwdm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mwdm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mwdm_pkg::*;

  logic [11:0] axle_sum_r;
  logic [15:0] duty_gain_r;
  logic [15:0] pwm_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axle_sum_r  <= AXLE_SUM_RST;
      duty_gain_r <= DUTY_GAIN_RST;
      pwm_top_r   <= PWM_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AXLE_SUM:  axle_sum_r  <= cfg_data[11:0];
        CFG_DUTY_GAIN: duty_gain_r <= cfg_data;
        CFG_PWM_TOP:   pwm_top_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = ~rst_n;

  logic accept;
  assign accept = start & ~busy;

  // stage 1: turn product and forward/side pair terms
  logic               s1_valid_r;
  logic               s1_stop_r;
  logic signed [28:0] s1_sum_r;
  logic signed [28:0] s1_dif_r;
  logic signed [28:0] s1_kw_r;
  logic signed [28:0] vx_q24;
  logic signed [28:0] vy_q24;
  logic signed [28:0] kw_nxt;

  assign vx_q24 = {in_req.fwd_speed[15], in_req.fwd_speed, 12'b0};
  assign vy_q24 = {in_req.side_speed[15], in_req.side_speed, 12'b0};
  assign kw_nxt = 29'($signed({1'b0, axle_sum_r})) * 29'($signed(in_req.turn_rate));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_stop_r <= in_req.stop;
    s1_sum_r  <= vx_q24 + vy_q24;
    s1_dif_r  <= vx_q24 - vy_q24;
    s1_kw_r   <= kw_nxt;
  end

  // stage 2: per-wheel mix, Q.24
  logic                    s2_valid_r;
  logic                    s2_stop_r;
  logic signed [29:0]      s2_mix_r [NUM_WHEELS];
  logic signed [29:0]      sum_e;
  logic signed [29:0]      dif_e;
  logic signed [29:0]      kw_e;

  assign sum_e = {s1_sum_r[28], s1_sum_r};
  assign dif_e = {s1_dif_r[28], s1_dif_r};
  assign kw_e  = {s1_kw_r[28], s1_kw_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_stop_r   <= s1_stop_r;
    s2_mix_r[0] <= dif_e - kw_e;  // front left
    s2_mix_r[1] <= sum_e - kw_e;  // rear left
    s2_mix_r[2] <= dif_e + kw_e;  // rear right
    s2_mix_r[3] <= sum_e + kw_e;  // front right
  end

  // stage 3: direction and magnitude
  logic        s3_valid_r;
  logic [28:0] s3_mag_r [NUM_WHEELS];
  dir_t        s3_dir_r [NUM_WHEELS];
  logic [28:0] mag_nxt  [NUM_WHEELS];
  dir_t        dir_nxt  [NUM_WHEELS];
  logic [29:0] neg_mix  [NUM_WHEELS];

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      neg_mix[w] = 30'(-s2_mix_r[w]);
      if (s2_stop_r || s2_mix_r[w] == 30'sd0) begin
        dir_nxt[w] = DIR_BRAKE;
        mag_nxt[w] = '0;
      end else if (s2_mix_r[w][29]) begin
        dir_nxt[w] = DIR_REVERSE;
        mag_nxt[w] = neg_mix[w][28:0];
      end else begin
        dir_nxt[w] = DIR_FORWARD;
        mag_nxt[w] = s2_mix_r[w][28:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_mag_r <= mag_nxt;
    s3_dir_r <= dir_nxt;
  end

  // stage 4: duty product
  logic        s4_valid_r;
  logic [44:0] s4_prod_r [NUM_WHEELS];
  dir_t        s4_dir_r  [NUM_WHEELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      s4_prod_r[w] <= 45'(s3_mag_r[w]) * 45'(duty_gain_r);
    end
    s4_dir_r <= s3_dir_r;
  end

  // stage 5: truncate and clamp into the output register
  logic [16:0] duty_raw [NUM_WHEELS];
  logic [15:0] duty_nxt [NUM_WHEELS];
  mwdm_out_t   out_res_nxt;
  logic        out_valid_r;
  mwdm_out_t   out_res_r;

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      duty_raw[w] = s4_prod_r[w][44:DUTY_SHIFT];
      if (duty_raw[w] > {1'b0, pwm_top_r}) begin
        duty_nxt[w] = pwm_top_r;
      end else begin
        duty_nxt[w] = duty_raw[w][15:0];
      end
    end
    out_res_nxt.front_left_duty  = duty_nxt[0];
    out_res_nxt.rear_left_duty   = duty_nxt[1];
    out_res_nxt.rear_right_duty  = duty_nxt[2];
    out_res_nxt.front_right_duty = duty_nxt[3];
    out_res_nxt.front_left_dir   = s4_dir_r[0];
    out_res_nxt.rear_left_dir    = s4_dir_r[1];
    out_res_nxt.rear_right_dir   = s4_dir_r[2];
    out_res_nxt.front_right_dir  = s4_dir_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef NO_ASSERTIONS
  // the result strobe matches each taken request, and only those
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(accept, 5))
    else $error("result strobe does not match request five cycles earlier");

  // a stop request brakes every wheel
  a_stop_brakes : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_req.stop, 5) |->
      out_res.front_left_dir == DIR_BRAKE && out_res.rear_left_dir == DIR_BRAKE &&
      out_res.rear_right_dir == DIR_BRAKE && out_res.front_right_dir == DIR_BRAKE)
    else $error("stop request did not brake all wheels");

  // front left brake always carries zero duty
  a_brake_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.front_left_dir == DIR_BRAKE |-> out_res.front_left_duty == 16'd0)
    else $error("front left brake with nonzero duty");

  // clamp holds
  a_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.front_left_duty <= pwm_top_r &&
      out_res.rear_left_duty <= pwm_top_r && out_res.rear_right_duty <= pwm_top_r &&
      out_res.front_right_duty <= pwm_top_r)
    else $error("duty above pwm top");
`endif

endmodule

`default_nettype wire

[dv/wheel_mix_checker.sv]
`timescale 1ns / 1ps

module wheel_mix_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  mwdm_pkg::mwdm_in_t              in_req,
  input  logic                            out_valid,
  input  mwdm_pkg::mwdm_out_t             out_res,
  input  logic                            cfg_we,
  input  logic [mwdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwdm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              outstanding
);
  import mwdm_pkg::*;

  logic [11:0] axle_sum_q;
  logic [15:0] duty_gain_q;
  logic [15:0] pwm_top_q;

  mwdm_out_t expected_wheel_q[$];

  // Q.24 wheel mixes, then |mix| * gain >> 28 clamped to the pwm top
  function automatic mwdm_out_t wheel_outputs_for(mwdm_in_t req);
    longint      vx, vy, kw, mag, duty;
    longint      mix [NUM_WHEELS];
    logic [15:0] duty_w [NUM_WHEELS];
    dir_t        dir_w [NUM_WHEELS];
    mwdm_out_t   res;
    vx = longint'($signed(req.fwd_speed)) * 4096;
    vy = longint'($signed(req.side_speed)) * 4096;
    kw = longint'(axle_sum_q) * longint'($signed(req.turn_rate));
    mix[0] = vx - vy - kw;
    mix[1] = vx + vy - kw;
    mix[2] = vx - vy + kw;
    mix[3] = vx + vy + kw;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      dir_w[w] = DIR_BRAKE;
      duty_w[w] = '0;
      if (!req.stop && mix[w] != 0) begin
        if (mix[w] > 0) begin
          dir_w[w] = DIR_FORWARD;
          mag = mix[w];
        end else begin
          dir_w[w] = DIR_REVERSE;
          mag = -mix[w];
        end
        duty = (mag * longint'(duty_gain_q)) >> DUTY_SHIFT;
        if (duty > longint'(pwm_top_q)) duty = longint'(pwm_top_q);
        duty_w[w] = duty[15:0];
      end
    end
    res.front_left_duty  = duty_w[0];
    res.rear_left_duty   = duty_w[1];
    res.rear_right_duty  = duty_w[2];
    res.front_right_duty = duty_w[3];
    res.front_left_dir   = dir_w[0];
    res.rear_left_dir    = dir_w[1];
    res.rear_right_dir   = dir_w[2];
    res.front_right_dir  = dir_w[3];
    return res;
  endfunction

  task automatic check_field(string field, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    mwdm_out_t exp_res;
    if (!rst_n) begin
      axle_sum_q  = AXLE_SUM_RST;
      duty_gain_q = DUTY_GAIN_RST;
      pwm_top_q   = PWM_TOP_RST;
      expected_wheel_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_wheel_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no request outstanding", $time);
        end else begin
          exp_res = expected_wheel_q.pop_front();
          check_field("front_left_duty", exp_res.front_left_duty, out_res.front_left_duty);
          check_field("rear_left_duty", exp_res.rear_left_duty, out_res.rear_left_duty);
          check_field("rear_right_duty", exp_res.rear_right_duty, out_res.rear_right_duty);
          check_field("front_right_duty", exp_res.front_right_duty,
                      out_res.front_right_duty);
          check_field("front_left_dir", exp_res.front_left_dir, out_res.front_left_dir);
          check_field("rear_left_dir", exp_res.rear_left_dir, out_res.rear_left_dir);
          check_field("rear_right_dir", exp_res.rear_right_dir, out_res.rear_right_dir);
          check_field("front_right_dir", exp_res.front_right_dir, out_res.front_right_dir);
        end
      end
      // unused index falls through and is ignored
      if (cfg_we) begin
        case (cfg_index)
          CFG_AXLE_SUM:  axle_sum_q  = cfg_data[11:0];
          CFG_DUTY_GAIN: duty_gain_q = cfg_data;
          CFG_PWM_TOP:   pwm_top_q   = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) expected_wheel_q.push_back(wheel_outputs_for(in_req));
    end
    outstanding = expected_wheel_q.size();
  end

endmodule

[dv/mecanum_wheel_drive_mixer_top_test.sv]
`timescale 1ns / 1ps

module mecanum_wheel_drive_mixer_top_test;
  import mwdm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  mwdm_in_t              in_req;
  logic                  out_valid;
  mwdm_out_t             out_res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    outstanding;
  bit                    no_idle;

  always #5 clk = ~clk;

  mecanum_wheel_drive_mixer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wheel_mix_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_res        (out_res),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  function automatic mwdm_in_t make_req(int fwd, int side, int turn, bit stop);
    mwdm_in_t r;
    r.fwd_speed  = fwd[15:0];
    r.side_speed = side[15:0];
    r.turn_rate  = turn[15:0];
    r.stop       = stop;
    return r;
  endfunction

  function automatic int boundary_speed();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int small_speed();
    return int'($urandom_range(0, 8)) - 4;
  endfunction

  function automatic mwdm_in_t random_request();
    mwdm_in_t r;
    int       fwd;
    fwd = int'($urandom_range(0, 65535));
    r = make_req(fwd, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 9) == 0);
    case ($urandom_range(0, 7))
      3: r = make_req(small_speed(), small_speed(), small_speed(), 1'b0);
      4: r = make_req(boundary_speed(), boundary_speed(), boundary_speed(), 1'b0);
      // equal or opposite fwd and side zero out a wheel pair's forward/side term
      5: r = make_req(fwd, $urandom_range(0, 1) ? fwd : -fwd,
                      $urandom_range(0, 1) ? 0 : small_speed(), 1'b0);
      6: r.stop = 1'b1;
      7: r = make_req(fwd, 0, small_speed(), 1'b0);
      default: ;
    endcase
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_request(mwdm_in_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic set_config(int axle, int gain, int top);
    write_reg(CFG_AXLE_SUM, axle[15:0]);
    write_reg(CFG_DUTY_GAIN, gain[15:0]);
    write_reg(CFG_PWM_TOP, top[15:0]);
    write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests on the reset settings
    send_request(make_req(0, 0, 0, 1'b0));
    send_request(make_req(32767, 32767, 32767, 1'b0));
    send_request(make_req(-32768, -32768, -32768, 1'b0));
    send_request(make_req(32767, -32768, 32767, 1'b0));
    send_request(make_req(-32768, 32767, -32768, 1'b0));
    send_request(make_req(1, 0, 0, 1'b0));
    send_request(make_req(-1, 0, 0, 1'b0));
    send_request(make_req(0, 1, 0, 1'b0));
    send_request(make_req(0, 0, 1, 1'b0));
    send_request(make_req(0, 0, -1, 1'b0));
    send_request(make_req(100, 100, 0, 1'b0));
    send_request(make_req(100, -100, 0, 1'b0));
    // turn term cancels the forward term on the left wheels
    send_request(make_req(1331, 0, 4096, 1'b0));
    send_request(make_req(32767, 32767, -32768, 1'b1));
    send_request(make_req(0, 0, 0, 1'b1));
    send_request(make_req($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), 1'b1));
    send_request(make_req(-32768, 0, 0, 1'b0));
    send_request(make_req(32767, 0, 0, 1'b0));
    send_request(make_req(0, -32768, 32767, 1'b0));
    send_request(make_req(8000, 0, 0, 1'b0));

    for (int phase = 0; phase < 9; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: set_config(4095, 65535, 65535);
          2: set_config(0, 0, 1);
          3: set_config(4095, 65535, 0);
          4: set_config(0, 65535, 65535);
          5: set_config(1, 1, 65535);
          default: set_config($urandom_range(0, 4095), $urandom_range(0, 65535),
                              $urandom_range(1, 65535));
        endcase
      end
      no_idle = (phase % 3 == 2);
      repeat (200) send_request(random_request());
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
